[rtl/tbd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbd_pkg
// shared widths, register indexes, constants and the kinematics result type
// ----------------------------------------------------------------------------
package tbd_pkg;

   localparam int unsigned CFG_W = 32;
   localparam int unsigned ANG_W = 16;
   localparam int unsigned MOM_W = 31;
   localparam int unsigned WGT_W = 26;
   localparam int unsigned IDX_W = 2;

   // register indexes
   localparam logic [IDX_W-1:0] REG_CM_ENERGY = IDX_W'(0);
   localparam logic [IDX_W-1:0] REG_MASS_ONE  = IDX_W'(1);
   localparam logic [IDX_W-1:0] REG_MASS_TWO  = IDX_W'(2);

   localparam logic [CFG_W-1:0] ECM_RESET   = 32'd1048576;
   localparam logic [30:0]      HALF_PI_Q30 = 31'd1686629713;
   localparam logic [30:0]      ONE_Q30     = 31'h4000_0000;
   localparam logic [WGT_W-1:0] WEIGHT_K    = 26'd56139751;

   // ceil(2^40 / k) for the taylor divisors, exact for 32-bit dividends
   localparam logic [39:0] SIN_RCP [5] = '{
      40'd9995560253, 40'd15270994831, 40'd26178848281,
      40'd54975581389, 40'd183251937963
   };
   localparam logic [39:0] COS_RCP [6] = '{
      40'd8329633544, 40'd12216795865, 40'd19634136211,
      40'd36650387593, 40'd91625968982, 40'd549755813888
   };

   typedef struct packed {
      logic [CFG_W-1:0] e_one;
      logic [CFG_W-1:0] e_two;
      logic [MOM_W-1:0] mom;
      logic [WGT_W-1:0] weight;
      logic             below;
   } kin_type;

endpackage

[rtl/tbd_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbd_req_if
// request channel: random polar cosine and azimuth
// ----------------------------------------------------------------------------
interface tbd_req_if
   import tbd_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic signed [ANG_W-1:0] cos_polar;
   logic        [ANG_W-1:0] azimuth;

   modport source (output valid, output cos_polar, output azimuth, input ready);
   modport sink   (input valid, input cos_polar, input azimuth, output ready);
endinterface

[rtl/tbd_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbd_rsp_if
// result channel: daughter energies, momentum vector, weight and flag
// ----------------------------------------------------------------------------
interface tbd_rsp_if
   import tbd_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic        [CFG_W-1:0] energy_one;
   logic        [CFG_W-1:0] energy_two;
   logic signed [CFG_W-1:0] mom_x;
   logic signed [CFG_W-1:0] mom_y;
   logic signed [CFG_W-1:0] mom_z;
   logic        [WGT_W-1:0] weight;
   logic                    below_threshold;

   modport source (output valid, output energy_one, output energy_two, output mom_x,
                   output mom_y, output mom_z, output weight, output below_threshold,
                   input ready);
   modport sink   (input valid, input energy_one, input energy_two, input mom_x,
                   input mom_y, input mom_z, input weight, input below_threshold,
                   output ready);
endinterface

[rtl/tbd_csr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbd_csr_if
// register write channel
// ----------------------------------------------------------------------------
interface tbd_csr_if
   import tbd_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] index;
   logic [CFG_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/two_body_decay_momenta_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_body_decay_momenta_top
// two-body decay kinematics: daughter energies, momentum vector, weight
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake      payload
//   req_bus   in    valid/ready    cos_polar (Q1.15), azimuth (turn/65536)
//   rsp_bus   out   valid/ready    energy_one/two, mom_x/y/z, weight, flag
//   csr_bus   in    valid/ready    index, data (cm_energy, mass_one, mass_two)
//
// one request a cycle unless setup or output stalls it; a stall stops only
// the stages behind a full one, so bubbles are squeezed out and nothing is lost
// after reset and after any register write the setup sequencer (shared 64-bit
// divider and square root, one bit a cycle) runs, stopping at the check state
// when below threshold; req ready is low meanwhile, register writes always taken
// reset is synchronous and clears the pipeline valid bits
//
module two_body_decay_momenta_top
   import tbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   tbd_req_if.sink    req_bus,
   tbd_rsp_if.source  rsp_bus,
   tbd_csr_if.sink    csr_bus
);

   // configuration registers
   logic [CFG_W-1:0] ecm_ff;
   logic [CFG_W-1:0] m1_ff;
   logic [CFG_W-1:0] m2_ff;
   logic             csr_wr;

   kin_type          kin;
   logic             busy;
   logic [CFG_W-1:0] pipe_x, pipe_y, pipe_z;

   // register writes never stall
   assign csr_bus.ready = 1'b1;
   assign csr_wr        = csr_bus.valid && csr_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ecm_ff <= ECM_RESET;
         m1_ff  <= '0;
         m2_ff  <= '0;
      end else if (csr_wr) begin
         case (csr_bus.index)
            REG_CM_ENERGY: ecm_ff <= csr_bus.data;
            REG_MASS_ONE:  m1_ff  <= csr_bus.data;
            REG_MASS_TWO:  m2_ff  <= csr_bus.data;
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   // energies, momentum magnitude and weight depend on the registers only
   tbd_setup u_setup (
      .clock (clock),
      .reset (reset),
      .start (csr_wr),
      .ecm   (ecm_ff),
      .m1    (m1_ff),
      .m2    (m2_ff),
      .kin   (kin),
      .busy  (busy)
   );

   // per-request angles and momentum vector
   tbd_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .en        (!busy),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .cos_polar (req_bus.cos_polar),
      .azimuth   (req_bus.azimuth),
      .mom       (kin.mom),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .mom_x     (pipe_x),
      .mom_y     (pipe_y),
      .mom_z     (pipe_z)
   );

   // below threshold the setup leaves energies, momentum and weight at zero
   assign rsp_bus.energy_one      = kin.e_one;
   assign rsp_bus.energy_two      = kin.e_two;
   assign rsp_bus.mom_x           = pipe_x;
   assign rsp_bus.mom_y           = pipe_y;
   assign rsp_bus.mom_z           = pipe_z;
   assign rsp_bus.weight          = kin.weight;
   assign rsp_bus.below_threshold = kin.below;

endmodule

[rtl/tbd_setup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbd_setup
// sequencer for the per-configuration terms: energies, momentum, weight
// ----------------------------------------------------------------------------
module tbd_setup
   import tbd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CFG_W-1:0] ecm,
   input  logic [CFG_W-1:0] m1,
   input  logic [CFG_W-1:0] m2,
   output kin_type          kin,
   output logic             busy
);

   typedef enum logic [14:0] {
      ST_IDLE   = 15'b000000000000001,
      ST_CHECK  = 15'b000000000000010,
      ST_MUL_D  = 15'b000000000000100,
      ST_DIV_D  = 15'b000000000001000,
      ST_ENERGY = 15'b000000000010000,
      ST_MUL_E  = 15'b000000000100000,
      ST_MUL_S  = 15'b000000001000000,
      ST_SQRT_P = 15'b000000010000000,
      ST_MUL_F  = 15'b000000100000000,
      ST_SQRT_Q = 15'b000001000000000,
      ST_MUL_PQ = 15'b000010000000000,
      ST_DIV_M  = 15'b000100000000000,
      ST_PREP_W = 15'b001000000000000,
      ST_DIV_W  = 15'b010000000000000,
      ST_MUL_W  = 15'b100000000000000
   } state_type;

   state_type   state_ff, state_in;
   logic [63:0] wa_ff, wa_in;      // dividend/quotient or radicand
   logic [63:0] wb_ff, wb_in;      // remainder or root
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] sum_ff, sum_in;
   logic [31:0] diff_ff, diff_in;
   logic        big1_ff, big1_in;
   logic [63:0] esq_ff, esq_in;
   logic [31:0] p_ff, p_in;
   kin_type     kin_ff, kin_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic [32:0] den;
   logic [33:0] rs, rem;
   logic        qbit;
   logic [63:0] bitv, trial, root_nx;
   logic        take;
   logic [32:0] sum33, el33;

   always_comb begin
      state_in = state_ff;
      wa_in    = wa_ff;
      wb_in    = wb_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      diff_in  = diff_ff;
      big1_in  = big1_ff;
      esq_in   = esq_ff;
      p_in     = p_ff;
      kin_in   = kin_ff;

      // one shared multiplier
      case (state_ff)
         ST_MUL_D: begin
            mul_a = sum_ff;
            mul_b = diff_ff;
         end
         ST_MUL_E: begin
            mul_a = ecm;
            mul_b = ecm;
         end
         ST_MUL_S: begin
            mul_a = sum_ff;
            mul_b = sum_ff;
         end
         ST_MUL_F: begin
            mul_a = diff_ff;
            mul_b = diff_ff;
         end
         ST_MUL_PQ: begin
            mul_a = p_ff;
            mul_b = wb_ff[31:0];
         end
         ST_MUL_W: begin
            mul_a = wa_ff[31:0];
            mul_b = 32'(WEIGHT_K);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod = 64'(mul_a) * 64'(mul_b);

      // restoring divider, one quotient bit a cycle
      den  = (state_ff == ST_DIV_M) ? {ecm, 1'b0} : {1'b0, ecm};
      rs   = {wb_ff[32:0], wa_ff[63]};
      qbit = (rs >= {1'b0, den});
      rem  = qbit ? (rs - {1'b0, den}) : rs;

      // square root, one result bit a cycle
      bitv    = 64'd1 << (7'd62 - 7'({cnt_ff[4:0], 1'b0}));
      trial   = wb_ff + bitv;
      take    = (wa_ff >= trial);
      root_nx = take ? ((wb_ff >> 1) + bitv) : (wb_ff >> 1);

      sum33 = {1'b0, m1} + {1'b0, m2};
      el33  = {1'b0, ecm} + {1'b0, wa_ff[31:0]};

      case (state_ff)
         ST_IDLE: begin
         end
         ST_CHECK: begin
            if ((ecm == '0) || ({1'b0, ecm} < sum33)) begin
               kin_in       = '0;
               kin_in.below = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               kin_in.below = 1'b0;
               big1_in      = (m1 >= m2);
               sum_in       = sum33[31:0];
               diff_in      = (m1 >= m2) ? (m1 - m2) : (m2 - m1);
               state_in     = ST_MUL_D;
            end
         end
         ST_MUL_D: begin
            wa_in    = prod;
            wb_in    = '0;
            cnt_in   = '0;
            state_in = ST_DIV_D;
         end
         ST_DIV_D, ST_DIV_M, ST_DIV_W: begin
            wa_in  = {wa_ff[62:0], qbit};
            wb_in  = 64'(rem[32:0]);
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               if (state_ff == ST_DIV_D) begin
                  state_in = ST_ENERGY;
               end else if (state_ff == ST_DIV_M) begin
                  state_in = ST_PREP_W;
               end else begin
                  state_in = ST_MUL_W;
               end
            end
         end
         ST_ENERGY: begin
            // heavier daughter takes (ecm + d/ecm)/2
            if (big1_ff) begin
               kin_in.e_one = el33[32:1];
               kin_in.e_two = ecm - el33[32:1];
            end else begin
               kin_in.e_two = el33[32:1];
               kin_in.e_one = ecm - el33[32:1];
            end
            state_in = ST_MUL_E;
         end
         ST_MUL_E: begin
            esq_in   = prod;
            state_in = ST_MUL_S;
         end
         ST_MUL_S: begin
            wa_in    = esq_ff - prod;
            wb_in    = '0;
            cnt_in   = '0;
            state_in = ST_SQRT_P;
         end
         ST_SQRT_P, ST_SQRT_Q: begin
            if (take) begin
               wa_in = wa_ff - trial;
            end
            wb_in  = root_nx;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff[4:0] == 5'd31) begin
               if (state_ff == ST_SQRT_P) begin
                  p_in     = root_nx[31:0];
                  state_in = ST_MUL_F;
               end else begin
                  state_in = ST_MUL_PQ;
               end
            end
         end
         ST_MUL_F: begin
            wa_in    = esq_ff - prod;
            wb_in    = '0;
            cnt_in   = '0;
            state_in = ST_SQRT_Q;
         end
         ST_MUL_PQ: begin
            wa_in    = prod;
            wb_in    = '0;
            cnt_in   = '0;
            state_in = ST_DIV_M;
         end
         ST_PREP_W: begin
            kin_in.mom = wa_ff[30:0];
            wa_in      = {wa_ff[31:0], 32'd0};
            wb_in      = '0;
            cnt_in     = '0;
            state_in   = ST_DIV_W;
         end
         ST_MUL_W: begin
            kin_in.weight = prod[57:32];
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (start) begin
         state_in = ST_CHECK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CHECK;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      wa_ff   <= wa_in;
      wb_ff   <= wb_in;
      cnt_ff  <= cnt_in;
      sum_ff  <= sum_in;
      diff_ff <= diff_in;
      big1_ff <= big1_in;
      esq_ff  <= esq_in;
      p_ff    <= p_in;
      kin_ff  <= kin_in;
   end

   assign kin  = kin_ff;
   assign busy = (state_ff != ST_IDLE);

endmodule

[rtl/tbd_pipe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbd_pipe
// per-request pipeline: sin of polar angle, sin/cos of azimuth, momentum vector
// ----------------------------------------------------------------------------
module tbd_pipe
   import tbd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [ANG_W-1:0] cos_polar,
   input  logic [ANG_W-1:0] azimuth,
   input  logic [MOM_W-1:0] mom,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [CFG_W-1:0] mom_x,
   output logic [CFG_W-1:0] mom_y,
   output logic [CFG_W-1:0] mom_z
);

   localparam int NST = 17;

   localparam logic [1:0] QUAD_I   = 2'd0;
   localparam logic [1:0] QUAD_II  = 2'd1;
   localparam logic [1:0] QUAD_III = 2'd2;
   localparam logic [1:0] QUAD_IV  = 2'd3;

   typedef struct packed {
      logic        cneg;
      logic [15:0] cmag;
      logic [1:0]  quad;
      logic [30:0] th;
      logic [31:0] t2;
      logic [31:0] sv;
      logic [31:0] sr;
      logic [30:0] ps;
      logic [30:0] pc;
      logic [31:0] xs;
      logic [31:0] xc;
      logic [31:0] sinv;
      logic [30:0] base;
      logic [30:0] mz;
      logic [30:0] cmp;
      logic [30:0] smp;
      logic        cphn;
      logic        sphn;
      logic [31:0] mx;
      logic [31:0] my;
      logic [31:0] ox;
      logic [31:0] oy;
      logic [31:0] oz;
   } stg_type;

   typedef struct packed {
      logic [31:0] v;
      logic [31:0] r;
   } sq_type;

   function automatic sq_type isq_step(input sq_type s, input logic [3:0] n);
      logic [31:0] b;
      logic [31:0] t;
      sq_type      o;
      b = 32'd1 << (5'd30 - {n, 1'b0});
      t = s.r + b;
      if (s.v >= t) begin
         o.v = s.v - t;
         o.r = (s.r >> 1) + b;
      end else begin
         o.v = s.v;
         o.r = s.r >> 1;
      end
      return o;
   endfunction

   // (a * b) >> 30
   function automatic logic [31:0] mul_q30(input logic [31:0] a, input logic [30:0] b);
      logic [62:0] p;
      p = 63'(a) * 63'(b);
      return p[61:30];
   endfunction

   // one horner step: saturating 1 - x/k, with x/k by reciprocal
   function automatic logic [30:0] hdiv(input logic [31:0] x, input logic [39:0] m);
      logic [71:0] p;
      logic [31:0] y;
      p = 72'(x) * 72'(m);
      y = p[71:40];
      return (y < 32'(ONE_Q30)) ? (ONE_Q30 - y[30:0]) : '0;
   endfunction

   stg_type        pl_ff [NST];
   stg_type        st_in [NST];
   logic [NST-1:0] v_ff;
   logic [NST-1:0] ld;
   logic           in_fire;

   logic [31:0] csq;
   logic [44:0] thp;
   logic [61:0] t2p;
   logic [46:0] bp;
   logic [46:0] zp;
   sq_type      sq;

   // a stage takes new data when it is empty or its content moves on
   always_comb begin
      ld[NST-1] = !v_ff[NST-1] || out_ready;
      for (int k = NST - 2; k >= 0; k--) begin
         ld[k] = !v_ff[k] || ld[k+1];
      end
   end

   assign in_ready = ld[0] && en;
   assign in_fire  = in_valid && in_ready;

   always_comb begin
      // stage 0: cosine magnitude, 1 - c^2, azimuth angle
      st_in[0]      = '0;
      st_in[0].cneg = cos_polar[15];
      st_in[0].cmag = cos_polar[15] ? (~cos_polar + 16'd1) : cos_polar;
      csq           = 32'(st_in[0].cmag) * 32'(st_in[0].cmag);
      st_in[0].sv   = 32'(ONE_Q30) - csq;
      st_in[0].quad = azimuth[15:14];
      thp           = 45'(azimuth[13:0]) * 45'(HALF_PI_Q30);
      st_in[0].th   = thp[44:14];

      for (int k = 1; k < NST; k++) begin
         st_in[k] = pl_ff[k-1];
      end

      // stage 1: theta squared, series seeds
      t2p         = 62'(pl_ff[0].th) * 62'(pl_ff[0].th);
      st_in[1].t2 = t2p[61:30];
      st_in[1].ps = ONE_Q30;
      st_in[1].pc = ONE_Q30;

      // stages 1 to 4: sin of polar angle, four root bits each
      for (int g = 0; g < 4; g++) begin
         sq.v = pl_ff[g].sv;
         sq.r = pl_ff[g].sr;
         for (int i = 0; i < 4; i++) begin
            sq = isq_step(sq, 4'(g * 4 + i));
         end
         st_in[g+1].sv = sq.v;
         st_in[g+1].sr = sq.r;
      end

      // stages 2 to 13: horner steps, multiply then divide
      for (int j = 0; j < 6; j++) begin
         st_in[2+2*j].xc = mul_q30(pl_ff[1+2*j].t2, pl_ff[1+2*j].pc);
         if (j < 5) begin
            st_in[2+2*j].xs = mul_q30(pl_ff[1+2*j].t2, pl_ff[1+2*j].ps);
         end else begin
            st_in[2+2*j].sinv = mul_q30(32'(pl_ff[1+2*j].th), pl_ff[1+2*j].ps);
         end
         st_in[3+2*j].pc = hdiv(pl_ff[2+2*j].xc, COS_RCP[j]);
         if (j < 5) begin
            st_in[3+2*j].ps = hdiv(pl_ff[2+2*j].xs, SIN_RCP[j]);
         end
      end

      // stage 14: quadrant, transverse and longitudinal magnitudes
      case (pl_ff[13].quad)
         QUAD_I: begin
            st_in[14].cmp  = pl_ff[13].pc;
            st_in[14].smp  = pl_ff[13].sinv[30:0];
            st_in[14].cphn = 1'b0;
            st_in[14].sphn = 1'b0;
         end
         QUAD_II: begin
            st_in[14].cmp  = pl_ff[13].sinv[30:0];
            st_in[14].smp  = pl_ff[13].pc;
            st_in[14].cphn = 1'b1;
            st_in[14].sphn = 1'b0;
         end
         QUAD_III: begin
            st_in[14].cmp  = pl_ff[13].pc;
            st_in[14].smp  = pl_ff[13].sinv[30:0];
            st_in[14].cphn = 1'b1;
            st_in[14].sphn = 1'b1;
         end
         QUAD_IV: begin
            st_in[14].cmp  = pl_ff[13].sinv[30:0];
            st_in[14].smp  = pl_ff[13].pc;
            st_in[14].cphn = 1'b0;
            st_in[14].sphn = 1'b1;
         end
         default: begin
            st_in[14].cmp  = pl_ff[13].pc;
            st_in[14].smp  = pl_ff[13].sinv[30:0];
            st_in[14].cphn = 1'b0;
            st_in[14].sphn = 1'b0;
         end
      endcase
      bp = 47'(mom) * 47'(pl_ff[13].sr[15:0]);
      zp = 47'(mom) * 47'(pl_ff[13].cmag);
      st_in[14].base = bp[45:15];
      st_in[14].mz   = zp[45:15];

      // stage 15: x and y magnitudes
      st_in[15].mx = mul_q30(32'(pl_ff[14].base), pl_ff[14].cmp);
      st_in[15].my = mul_q30(32'(pl_ff[14].base), pl_ff[14].smp);

      // stage 16: signs, truncation toward zero
      st_in[16].ox = pl_ff[15].cphn ? (32'd0 - pl_ff[15].mx) : pl_ff[15].mx;
      st_in[16].oy = pl_ff[15].sphn ? (32'd0 - pl_ff[15].my) : pl_ff[15].my;
      st_in[16].oz = pl_ff[15].cneg ? (32'd0 - 32'(pl_ff[15].mz)) : 32'(pl_ff[15].mz);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (ld[0]) begin
            v_ff[0] <= in_fire;
         end
         for (int k = 1; k < NST; k++) begin
            if (ld[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NST; k++) begin
         if (ld[k]) begin
            pl_ff[k] <= st_in[k];
         end
      end
   end

   assign out_valid = v_ff[NST-1];
   assign mom_x     = pl_ff[NST-1].ox;
   assign mom_y     = pl_ff[NST-1].oy;
   assign mom_z     = pl_ff[NST-1].oz;

endmodule

[test/two_body_decay_momenta_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_body_decay_momenta_top_test
// Self-checking bench for the two-body decay kinematics block. It drives
// random polar cosines and azimuths under several energy and mass settings.
// Every accepted request is run through a bit-exact fixed-point model of the
// kinematics. Each result is checked field by field against the oldest
// prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module two_body_decay_momenta_top_test;
   import tbd_pkg::*;

   localparam int                 CYCLE_LIMIT = 600000;
   localparam logic [IDX_W-1:0]   REG_SPARE   = IDX_W'(3);   // unmapped index
   localparam longint unsigned    Q30         = 64'd1 << 30;
   localparam logic [31:0]        ALL_ONES    = 32'hFFFF_FFFF;

   // one predicted or observed decay event
   typedef struct {
      logic [31:0] e_one;
      logic [31:0] e_two;
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] pz;
      logic [25:0] wgt;
      logic        below;
   } decay_event_type;

   // kinematics predictor and queue of pending decay events
   class decay_scoreboard;
      longint unsigned ecm, m_one, m_two;
      decay_event_type pending_events[$];
      int              errors, checked, requests;

      function new();
         ecm = ECM_RESET; m_one = 0; m_two = 0;
         errors = 0; checked = 0; requests = 0;
      endfunction

      function void set_register(logic [IDX_W-1:0] idx, logic [31:0] val);
         case (idx)
            REG_CM_ENERGY: ecm = val;
            REG_MASS_ONE:  m_one = val;
            REG_MASS_TWO:  m_two = val;
            default: ;
         endcase
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned r, b;
         r = 0; b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // truncating horner step, floored at zero
      function longint unsigned series_step(longint unsigned t2, longint unsigned p,
                                            longint unsigned k);
         longint unsigned t;
         t = ((t2 * p) >> 30) / k;
         return (Q30 > t) ? Q30 - t : 0;
      endfunction

      function logic [31:0] apply_sign(longint unsigned mag, bit neg);
         logic [31:0] m;
         m = mag[31:0];
         return neg ? -m : m;
      endfunction

      function void note_request(logic [15:0] cos_raw, logic [15:0] az);
         decay_event_type ev;
         longint unsigned big, lit, sum, diff, el, p, q, mom, cmag, sint;
         longint unsigned th, t2, pp, sq, cq, cphi, sphi, base, wr;
         bit              cneg, cphi_neg, sphi_neg;
         ev = '{default: '0};
         requests++;
         if (ecm == 0 || ecm < m_one + m_two) begin
            ev.below = 1'b1;
            pending_events.push_back(ev);
            return;
         end
         cneg = cos_raw[15];
         cmag = cneg ? (64'h10000 - cos_raw) : cos_raw;
         big  = (m_one >= m_two) ? m_one : m_two;
         lit  = (m_one >= m_two) ? m_two : m_one;
         sum  = big + lit;
         diff = big - lit;
         el   = (ecm + (sum * diff) / ecm) >> 1;
         if (m_one >= m_two) begin
            ev.e_one = 32'(el); ev.e_two = 32'(ecm - el);
         end else begin
            ev.e_two = 32'(el); ev.e_one = 32'(ecm - el);
         end
         p    = int_sqrt(ecm * ecm - sum * sum);
         q    = int_sqrt(ecm * ecm - diff * diff);
         mom  = (p * q) / (2 * ecm);
         sint = int_sqrt(Q30 - cmag * cmag);
         // quarter-wave sine and cosine of the azimuth remainder
         th = ({50'd0, az[13:0]} * HALF_PI_Q30) >> 14;
         t2 = (th * th) >> 30;
         pp = Q30;
         pp = series_step(t2, pp, 110); pp = series_step(t2, pp, 72);
         pp = series_step(t2, pp, 42);  pp = series_step(t2, pp, 20);
         pp = series_step(t2, pp, 6);
         sq = (th * pp) >> 30;
         pp = Q30;
         pp = series_step(t2, pp, 132); pp = series_step(t2, pp, 90);
         pp = series_step(t2, pp, 56);  pp = series_step(t2, pp, 30);
         pp = series_step(t2, pp, 12);  pp = series_step(t2, pp, 2);
         cq = pp;
         case (az[15:14])
            2'd0: begin cphi = cq; cphi_neg = 0; sphi = sq; sphi_neg = 0; end
            2'd1: begin cphi = sq; cphi_neg = 1; sphi = cq; sphi_neg = 0; end
            2'd2: begin cphi = cq; cphi_neg = 1; sphi = sq; sphi_neg = 1; end
            default: begin cphi = sq; cphi_neg = 0; sphi = cq; sphi_neg = 1; end
         endcase
         base   = (mom * sint) >> 15;
         wr     = (mom << 32) / ecm;
         ev.px  = apply_sign((base * cphi) >> 30, cphi_neg);
         ev.py  = apply_sign((base * sphi) >> 30, sphi_neg);
         ev.pz  = apply_sign((mom * cmag) >> 15, cneg);
         ev.wgt = 26'((wr * WEIGHT_K) >> 32);
         pending_events.push_back(ev);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, checked);
      endtask

      task check_result(decay_event_type got);
         decay_event_type want;
         if (pending_events.size() == 0) begin
            report("unexpected result", got.e_one, 32'd0);
            return;
         end
         want = pending_events.pop_front();
         if (got.e_one !== want.e_one) report("energy_one", got.e_one, want.e_one);
         if (got.e_two !== want.e_two) report("energy_two", got.e_two, want.e_two);
         if (got.px !== want.px) report("mom_x", got.px, want.px);
         if (got.py !== want.py) report("mom_y", got.py, want.py);
         if (got.pz !== want.pz) report("mom_z", got.pz, want.pz);
         if (got.wgt !== want.wgt) report("weight", got.wgt, want.wgt);
         if (got.below !== want.below) report("below_threshold", got.below, want.below);
         checked++;
      endtask
   endclass

   logic clock;
   logic reset;
   int   cycles;
   bit   idle_on;     // random stalls enabled for this phase
   int   rsp_hold;
   int   config_count;

   tbd_req_if req_bus ();
   tbd_rsp_if rsp_bus ();
   tbd_csr_if csr_bus ();

   decay_scoreboard board;

   two_body_decay_momenta_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   always #5 clock = ~clock;

   // mostly short gaps, now and then a long one
   function int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_on || roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // cycle counter and timeout guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("[two_body_decay_momenta_top] ERROR");
         $finish;
      end
   end

   // result side back-pressure, changed on the falling edge
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_bus.ready = 1'b0;
         rsp_hold--;
      end else begin
         rsp_bus.ready = 1'b1;
         if (idle_on && $urandom_range(0, 99) < 15) rsp_hold = pick_gap() + 1;
      end
   end

   // monitor: predict on each accepted request, check each accepted result
   always @(posedge clock) begin
      decay_event_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) board.note_request(req_bus.cos_polar,
                                                                req_bus.azimuth);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.e_one = rsp_bus.energy_one;
            got.e_two = rsp_bus.energy_two;
            got.px    = rsp_bus.mom_x;
            got.py    = rsp_bus.mom_y;
            got.pz    = rsp_bus.mom_z;
            got.wgt   = rsp_bus.weight;
            got.below = rsp_bus.below_threshold;
            board.check_result(got);
         end
      end
   end

   // one register write; the model copy is updated when it is taken
   task write_register(logic [IDX_W-1:0] idx, logic [31:0] val);
      csr_bus.index = idx;
      csr_bus.data  = val;
      csr_bus.valid = 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      board.set_register(idx, val);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task load_setting(logic [31:0] e, logic [31:0] m1, logic [31:0] m2);
      write_register(REG_CM_ENERGY, e);
      write_register(REG_MASS_ONE, m1);
      write_register(REG_MASS_TWO, m2);
      config_count++;
   endtask

   // valid stays high across back-to-back requests
   task send_request(logic [15:0] c, logic [15:0] az);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.cos_polar = c;
      req_bus.azimuth   = az;
      req_bus.valid     = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // let every pending result come back, then let the pipeline settle
   task drain();
      req_bus.valid = 1'b0;
      while (board.pending_events.size() > 0) @(posedge clock);
      repeat (25) @(posedge clock);
      @(negedge clock);
   endtask

   task random_burst(int count);
      logic [15:0] c;
      int          k;
      for (k = 0; k < count; k++) begin
         c = 16'($urandom);
         case ($urandom_range(0, 19))
            0: c = 16'h8000;
            1: c = 16'h7FFF;
            2: c = 16'h0000;
            default: ;
         endcase
         send_request(c, 16'($urandom));
      end
   endtask

   initial begin
      logic [31:0] e, a, b;
      int          ph;
      clock = 0; reset = 1; cycles = 0; idle_on = 0; rsp_hold = 0; config_count = 0;
      board = new();
      req_bus.valid = 0; req_bus.cos_polar = '0; req_bus.azimuth = '0;
      csr_bus.valid = 0; csr_bus.index = '0; csr_bus.data = '0;
      rsp_bus.ready = 1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: reset setting, cosine and azimuth extremes, quadrant edges
      send_request(16'h8000, 16'h0000);   // cosine of minus one
      send_request(16'h7FFF, 16'hFFFF);
      send_request(16'h0000, 16'h3FFF);
      send_request(16'h0001, 16'h4000);
      send_request(16'hFFFF, 16'h8000);
      send_request(16'h4000, 16'hC000);
      send_request(16'hC000, 16'h7FFF);
      send_request(16'h5555, 16'hAAAA);
      send_request(16'hAAAA, 16'h5555);
      send_request(16'h8000, 16'hBFFF);
      drain();
      // zero energy
      load_setting(32'd0, 32'd0, 32'd0);
      send_request(16'h1234, 16'h4321);
      send_request(16'h8000, 16'hFFFF);
      drain();
      // exactly at threshold, largest values
      load_setting(ALL_ONES, ALL_ONES, 32'd0);
      send_request(16'h7FFF, 16'h2000);
      send_request(16'h8000, 16'hE000);
      drain();
      // largest energy, massless daughters
      load_setting(ALL_ONES, 32'd0, 32'd0);
      send_request(16'h8000, 16'h0000);
      send_request(16'h7FFF, 16'h6000);
      send_request(16'h0000, 16'hA000);
      drain();
      // above threshold, second mass heavier, plus an ignored unmapped write
      load_setting(32'h0010_0000, 32'h0000_8000, 32'h0009_0000);
      write_register(REG_SPARE, 32'hDEAD_BEEF);
      send_request(16'h2222, 16'h3333);
      drain();
      load_setting(32'h0300_0000, 32'h0000_8000, 32'h0100_0000);
      send_request(16'h8000, 16'h1111);
      send_request(16'h7FFF, 16'hF0F0);
      drain();

      // random phases; the first and last with no idling
      for (ph = 0; ph < 11; ph++) begin
         idle_on = (ph != 0 && ph != 10);
         e = $urandom;
         case (ph % 4)
            0: begin a = $urandom_range(0, e / 2); b = $urandom_range(0, e / 2); end
            1: begin a = $urandom_range(0, e / 8); b = $urandom_range(0, e - a); end
            2: begin a = $urandom; b = $urandom; end   // mostly below threshold
            default: begin
               e = $urandom_range(1, 32'h0040_0000);
               a = $urandom_range(0, e / 3);
               b = $urandom_range(0, e / 3);
            end
         endcase
         load_setting(e, a, b);
         random_burst(78);
         drain();
      end

      $display("covered %0d requests and %0d results over %0d register settings",
               board.requests, board.checked, config_count);
      if (board.errors == 0)
         $display("[two_body_decay_momenta_top] OK");
      else
         $display("[two_body_decay_momenta_top] ERROR");
      $finish;
   end

endmodule
